[design/assert_macros.svh]
// Assertion macros for the checker file of the vertex generator.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every rising edge outside reset.
`define SCV_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold at the next rising edge.
`define SCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/scv_pkg.sv]
// Package for the score colormap vertex generator: field widths, pipeline
// depth, reciprocal constants and the gradient tables. Depends on nothing.
`default_nettype none

package scv_pkg;

    // Field widths
    localparam int DAY_W    = 8;
    localparam int BUCKET_W = 10;
    localparam int SCORE_W  = 16;
    localparam int POS_W    = 16;
    localparam int POSZ_W   = 24;
    localparam int COLOR_W  = 8;
    localparam int ZSP_W    = 16;

    // Defaults of the top-level parameters
    localparam int DAY_COUNT_MAX_DEF    = 256;
    localparam int BUCKET_COUNT_MAX_DEF = 1024;

    // Number of register stages from input to output
    localparam int NUM_STAGES = 5;

    // Divide by 25 of an 18-bit value: multiply, then shift
    localparam int          X_NUM_W = 18;
    localparam int          X_MUL_W = 19;
    localparam int          X_SHIFT = 23;
    localparam logic [X_MUL_W-1:0] X_MUL = 19'd335545;
    localparam logic [X_NUM_W-1:0] X_BIAS = 18'd12;

    // Divide by 5 of a 17-bit value
    localparam int          Y_NUM_W = 17;
    localparam int          Y_MUL_W = 18;
    localparam int          Y_SHIFT = 20;
    localparam logic [Y_MUL_W-1:0] Y_MUL = 18'd209716;
    localparam logic [Y_NUM_W-1:0] Y_BIAS = 17'd2;

    // t = floor(score * 64 / 15) as score * T_MUL >> T_SHIFT
    localparam int          T_MUL_W = 23;
    localparam int          T_SHIFT = 20;
    localparam int          T_RAW_W = 19;
    localparam logic [T_MUL_W-1:0] T_MUL = 23'd4473925;

    // Gradient position, Q1.16 with one at 2^16
    localparam int          T_W   = 17;
    localparam logic [T_W-1:0] T_ONE = 17'd65536;

    localparam int NUM_SEGS = 6;
    localparam int SEG_W    = 3;
    localparam int RECIP_W  = 20;
    localparam int FPROD_W  = T_W + RECIP_W;
    localparam int STEP_W   = T_W + COLOR_W;

    localparam logic [T_W-1:0] STOP_POS [0:NUM_SEGS] = '{
        17'd0, 17'd9830, 17'd19661, 17'd32768, 17'd45875, 17'd58982, 17'd65536
    };

    localparam logic [RECIP_W-1:0] SEG_RECIP [0:NUM_SEGS-1] = '{
        20'd436924, 20'd436880, 20'd327685, 20'd327685, 20'd327685, 20'd655320
    };

    // Stop colours, red, green, blue
    localparam logic [COLOR_W-1:0] STOP_RGB [0:NUM_SEGS][0:2] = '{
        '{8'h14, 8'h23, 8'h3C},
        '{8'h26, 8'h4B, 8'h93},
        '{8'h50, 8'hC7, 8'hE0},
        '{8'h67, 8'hBD, 8'hAF},
        '{8'hDC, 8'h79, 8'h69},
        '{8'hF4, 8'h84, 8'h20},
        '{8'hEC, 8'h0F, 8'h6C}
    };

    // Per-stage load enables from the pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } scv_pipe_t;

endpackage

`default_nettype wire

[design/scv_if.sv]
// Valid/ready channel interfaces for samples, vertices and the spacing register.
// Depends on scv_pkg for the field widths.
`default_nettype none

interface scv_sample_if
    import scv_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [DAY_W-1:0]    day_index;
    logic [BUCKET_W-1:0] bucket_index;
    logic [SCORE_W-1:0]  score;

    modport source (output valid, day_index, bucket_index, score, input ready);
    modport sink   (input valid, day_index, bucket_index, score, output ready);
endinterface

interface scv_vertex_if
    import scv_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POSZ_W-1:0]  pos_z;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (output valid, pos_x, pos_y, pos_z, red, green, blue, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, red, green, blue, output ready);
endinterface

interface scv_cfg_if
    import scv_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ZSP_W-1:0] row_pitch;

    modport source (output valid, row_pitch, input ready);
    modport sink   (input valid, row_pitch, output ready);
endinterface

`default_nettype wire

[design/scv_pipe_ctrl.sv]
// Valid bits and stall control of the vertex pipeline.
// Depends on scv_pkg for the stage count and the load-enable struct.
`default_nettype none

module scv_pipe_ctrl
    import scv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output scv_pipe_t ctrl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] up_valid;
    logic [NUM_STAGES:0]   stage_ready;

    // A stage can take a request when it is empty or its content moves on.
    always_comb
    begin
        stage_ready[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k + 1];
        end
    end

    assign up_valid = {valid_reg[NUM_STAGES-2:0], in_valid};

    always_comb
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            ctrl.load[k]  = up_valid[k] && stage_ready[k];
            valid_next[k] = stage_ready[k] ? up_valid[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

`default_nettype wire

[design/scv_position.sv]
// Position path: x = bucket*256/25 and y = score/5, both rounded, by
// reciprocal multiplication, and z = day * spacing, then all delayed to
// line up with the colour path. Depends on scv_pkg.
`default_nettype none

module scv_position
    import scv_pkg::*;
#(
    parameter int DAY_COUNT_MAX    = DAY_COUNT_MAX_DEF,
    parameter int BUCKET_COUNT_MAX = BUCKET_COUNT_MAX_DEF
)
(
    input  logic                clk,
    input  scv_pipe_t           ctrl,
    input  logic [DAY_W-1:0]    day_index,
    input  logic [BUCKET_W-1:0] bucket_index,
    input  logic [SCORE_W-1:0]  score,
    input  logic [ZSP_W-1:0]    row_pitch,
    output logic [POS_W-1:0]    pos_x,
    output logic [POS_W-1:0]    pos_y,
    output logic [POSZ_W-1:0]   pos_z
);

    localparam int LIM_W = 17;
    localparam logic [LIM_W-1:0] DAY_LIM     = LIM_W'(DAY_COUNT_MAX);
    localparam logic [LIM_W-1:0] DAY_LAST    = LIM_W'(DAY_COUNT_MAX - 1);
    localparam logic [LIM_W-1:0] BUCKET_LIM  = LIM_W'(BUCKET_COUNT_MAX);
    localparam logic [LIM_W-1:0] BUCKET_LAST = LIM_W'(BUCKET_COUNT_MAX - 1);

    localparam int XP_W = X_NUM_W + X_MUL_W;
    localparam int YP_W = Y_NUM_W + Y_MUL_W;

    logic [DAY_W-1:0]    day_sat;
    logic [BUCKET_W-1:0] bucket_sat;
    logic [X_NUM_W-1:0]  x_num;
    logic [Y_NUM_W-1:0]  y_num;
    logic [XP_W-1:0]     x_prod_next;
    logic [YP_W-1:0]     y_prod_next;
    logic [POSZ_W-1:0]   z_next;

    logic [XP_W-1:0]     x_prod_reg;
    logic [YP_W-1:0]     y_prod_reg;
    logic [POSZ_W-1:0]   z_prod_reg;

    logic [POS_W-1:0]    pos_x_reg [1:NUM_STAGES-1];
    logic [POS_W-1:0]    pos_y_reg [1:NUM_STAGES-1];
    logic [POSZ_W-1:0]   pos_z_reg [1:NUM_STAGES-1];

    // Clamp the indices to the configured counts and form the products.
    always_comb
    begin
        day_sat    = (LIM_W'(day_index) >= DAY_LIM) ? DAY_LAST[DAY_W-1:0] : day_index;
        bucket_sat = (LIM_W'(bucket_index) >= BUCKET_LIM) ?
                     BUCKET_LAST[BUCKET_W-1:0] : bucket_index;
        x_num       = {bucket_sat, 8'd0} + X_BIAS;
        y_num       = Y_NUM_W'(score) + Y_BIAS;
        x_prod_next = XP_W'(x_num) * XP_W'(X_MUL);
        y_prod_next = YP_W'(y_num) * YP_W'(Y_MUL);
        z_next      = POSZ_W'(day_sat) * POSZ_W'(row_pitch);
    end

    // Stage 0: products.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            x_prod_reg <= x_prod_next;
            y_prod_reg <= y_prod_next;
            z_prod_reg <= z_next;
        end
    end

    // Stage 1: quotients by shifting; later stages only carry them along.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            pos_x_reg[1] <= POS_W'(x_prod_reg >> X_SHIFT);
            pos_y_reg[1] <= POS_W'(y_prod_reg >> Y_SHIFT);
            pos_z_reg[1] <= z_prod_reg;
        end
        for (int k = 2; k < NUM_STAGES; k++)
        begin
            if (ctrl.load[k])
            begin
                pos_x_reg[k] <= pos_x_reg[k-1];
                pos_y_reg[k] <= pos_y_reg[k-1];
                pos_z_reg[k] <= pos_z_reg[k-1];
            end
        end
    end

    assign pos_x = pos_x_reg[NUM_STAGES-1];
    assign pos_y = pos_y_reg[NUM_STAGES-1];
    assign pos_z = pos_z_reg[NUM_STAGES-1];

endmodule

`default_nettype wire

[design/scv_color.sv]
// Colour path: gradient position from the score, segment search, fraction by
// per-segment reciprocal and linear blend of the stop colours. Depends on scv_pkg.
`default_nettype none

module scv_color
    import scv_pkg::*;
(
    input  logic               clk,
    input  scv_pipe_t          ctrl,
    input  logic [SCORE_W-1:0] score,
    output logic [COLOR_W-1:0] red,
    output logic [COLOR_W-1:0] green,
    output logic [COLOR_W-1:0] blue
);

    localparam int TP_W = SCORE_W + T_MUL_W;

    logic [TP_W-1:0]    t_prod_reg;
    logic [SEG_W-1:0]   seg1_reg;
    logic [T_W-1:0]     tdiff_reg;
    logic [SEG_W-1:0]   seg2_reg;
    logic [FPROD_W-1:0] f_prod_reg;
    logic [SEG_W-1:0]   seg3_reg;
    logic [STEP_W-1:0]  step_prod_reg [0:2];
    logic [COLOR_W-1:0] rgb_reg [0:2];

    logic [T_RAW_W-1:0] t_raw;
    logic [T_W-1:0]     t_val;
    logic [SEG_W-1:0]   seg_next;
    logic [T_W-1:0]     tdiff_next;
    logic [FPROD_W-1:0] f_round;
    logic [T_W-1:0]     f_val;
    logic [STEP_W-1:0]  step_prod_next [0:2];
    logic [COLOR_W-1:0] rgb_next [0:2];

    // Stage 0: score times the reciprocal of 15/64.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            t_prod_reg <= TP_W'(score) * TP_W'(T_MUL);
        end
    end

    // Stage 1: saturate t and pick the first segment whose upper stop covers it.
    always_comb
    begin
        t_raw = T_RAW_W'(t_prod_reg >> T_SHIFT);
        t_val = (t_raw > T_RAW_W'(T_ONE)) ? T_ONE : t_raw[T_W-1:0];
        seg_next = SEG_W'(NUM_SEGS - 1);
        for (int i = NUM_SEGS - 1; i >= 0; i--)
        begin
            if (t_val <= STOP_POS[i + 1])
            begin
                seg_next = SEG_W'(i);
            end
        end
        tdiff_next = (t_val >= STOP_POS[seg_next]) ? t_val - STOP_POS[seg_next] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            seg1_reg  <= seg_next;
            tdiff_reg <= tdiff_next;
        end
    end

    // Stage 2: offset within the segment times its reciprocal width.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            seg2_reg   <= seg1_reg;
            f_prod_reg <= FPROD_W'(tdiff_reg) * FPROD_W'(SEG_RECIP[seg1_reg]);
        end
    end

    // Stage 3: round and saturate the fraction, scale each channel's span.
    always_comb
    begin
        f_round = f_prod_reg + FPROD_W'(32768);
        f_val   = ((f_round >> 16) > FPROD_W'(T_ONE)) ? T_ONE : T_W'(f_round >> 16);
        for (int c = 0; c < 3; c++)
        begin
            if (STOP_RGB[seg2_reg + 3'd1][c] >= STOP_RGB[seg2_reg][c])
            begin
                step_prod_next[c] = STEP_W'(f_val) *
                    STEP_W'(STOP_RGB[seg2_reg + 3'd1][c] - STOP_RGB[seg2_reg][c]);
            end
            else
            begin
                step_prod_next[c] = STEP_W'(f_val) *
                    STEP_W'(STOP_RGB[seg2_reg][c] - STOP_RGB[seg2_reg + 3'd1][c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            seg3_reg <= seg2_reg;
            for (int c = 0; c < 3; c++)
            begin
                step_prod_reg[c] <= step_prod_next[c];
            end
        end
    end

    // Stage 4: round the step and move from the lower stop towards the upper.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (STOP_RGB[seg3_reg + 3'd1][c] >= STOP_RGB[seg3_reg][c])
            begin
                rgb_next[c] = STOP_RGB[seg3_reg][c] +
                    COLOR_W'((step_prod_reg[c] + STEP_W'(32768)) >> 16);
            end
            else
            begin
                rgb_next[c] = STOP_RGB[seg3_reg][c] -
                    COLOR_W'((step_prod_reg[c] + STEP_W'(32768)) >> 16);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            for (int c = 0; c < 3; c++)
            begin
                rgb_reg[c] <= rgb_next[c];
            end
        end
    end

    assign red   = rgb_reg[0];
    assign green = rgb_reg[1];
    assign blue  = rgb_reg[2];

endmodule

`default_nettype wire

[design/score_colormap_vertex_gen.sv]
// Score colormap vertex generator: one vertex with position and colour per sample.
// Each sample is registered through every pipeline stage before it is offered as a vertex.
// Throughput: one sample per cycle while the output is not stalled.
// An output stall holds the full stages in place; empty stages behind them still fill.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the row pitch to 1.0.
// Depends on scv_pkg, the channel interfaces, scv_pipe_ctrl, scv_position, scv_color.
`default_nettype none

module score_colormap_vertex_gen
    import scv_pkg::*;
#(
    parameter int DAY_COUNT_MAX    = DAY_COUNT_MAX_DEF,
    parameter int BUCKET_COUNT_MAX = BUCKET_COUNT_MAX_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    scv_sample_if.sink    sample_in,
    scv_vertex_if.source  vertex_out,
    scv_cfg_if.sink       cfg
);

    localparam logic [ZSP_W-1:0] ROW_PITCH_RESET = 16'd256;

    logic [ZSP_W-1:0] row_pitch_reg;
    logic [ZSP_W-1:0] row_pitch_next;
    scv_pipe_t        ctrl;

    // Row pitch register; writes are always taken.
    assign cfg.ready      = 1'b1;
    assign row_pitch_next = cfg.valid ? cfg.row_pitch : row_pitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pitch_reg <= ROW_PITCH_RESET;
        end
        else
        begin
            row_pitch_reg <= row_pitch_next;
        end
    end

    // Pipeline control.
    scv_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .out_valid (vertex_out.valid),
        .out_ready (vertex_out.ready),
        .ctrl      (ctrl)
    );

    // Position path.
    scv_position #(
        .DAY_COUNT_MAX    (DAY_COUNT_MAX),
        .BUCKET_COUNT_MAX (BUCKET_COUNT_MAX)
    ) u_position (
        .clk          (clk),
        .ctrl         (ctrl),
        .day_index    (sample_in.day_index),
        .bucket_index (sample_in.bucket_index),
        .score        (sample_in.score),
        .row_pitch    (row_pitch_reg),
        .pos_x        (vertex_out.pos_x),
        .pos_y        (vertex_out.pos_y),
        .pos_z        (vertex_out.pos_z)
    );

    // Colour path.
    scv_color u_color (
        .clk   (clk),
        .ctrl  (ctrl),
        .score (sample_in.score),
        .red   (vertex_out.red),
        .green (vertex_out.green),
        .blue  (vertex_out.blue)
    );

endmodule

`default_nettype wire

[design/scv_checker.sv]
// Port-level checks of the vertex generator, bound to the top level.
// Depends on scv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module scv_checker
    import scv_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [POS_W-1:0]   pos_x,
    input logic [POS_W-1:0]   pos_y,
    input logic [POSZ_W-1:0]  pos_z,
    input logic [COLOR_W-1:0] red,
    input logic [COLOR_W-1:0] green,
    input logic [COLOR_W-1:0] blue
);

    // A waiting vertex stays offered until it is taken.
    `SCV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
        "vertex dropped while stalled")

    // A waiting vertex keeps its payload.
    `SCV_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
        $stable(pos_x) && $stable(pos_y) && $stable(pos_z) && $stable(red) && $stable(green) && $stable(blue),
        "vertex payload changed while stalled")

    // With the output side ready, no stage can hold back a new sample.
    `SCV_ASSERT_ALWAYS(a_ready_chain, clk, rst_n, !out_ready || in_ready,
        "sample refused although the output is ready")

    // A score below one step of y lies at the very start of the gradient.
    `SCV_ASSERT_ALWAYS(a_low_score_color, clk, rst_n,
        !(out_valid && pos_y == '0) ||
        (red == STOP_RGB[0][0] && green == STOP_RGB[0][1] && blue == STOP_RGB[0][2]),
        "low score does not give the first stop colour")

endmodule

bind score_colormap_vertex_gen scv_checker u_scv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (sample_in.ready),
    .out_valid (vertex_out.valid),
    .out_ready (vertex_out.ready),
    .pos_x     (vertex_out.pos_x),
    .pos_y     (vertex_out.pos_y),
    .pos_z     (vertex_out.pos_z),
    .red       (vertex_out.red),
    .green     (vertex_out.green),
    .blue      (vertex_out.blue)
);

`default_nettype wire

[tb/score_colormap_vertex_gen_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for score_colormap_vertex_gen: bursty sample requests,
// patterned output stalls, every vertex compared with an in-bench predictor or typed row.
// Depends on scv_pkg, the scv channel interfaces and the block itself.

module score_colormap_vertex_gen_test
    import scv_pkg::*;
();

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int REPORT_LIMIT    = 10;
    localparam int DRAIN_CYCLES    = NUM_STAGES + 8;
    localparam int TIMEOUT_NS      = 2000000;
    localparam int SPACING_RESET   = 256;
    localparam int STIM_ROWS       = 18;
    localparam int EXPECT_DEPTH    = 64;

    // Gradient stops: Q1.16 positions, segment reciprocals and stop colours as RGB.
    localparam int GRAD_SEGS = 6;
    localparam logic [0:6][16:0] GRAD_POS = {
        17'd0, 17'd9830, 17'd19661, 17'd32768, 17'd45875, 17'd58982, 17'd65536
    };
    localparam logic [0:5][19:0] GRAD_RECIP = {
        20'd436924, 20'd436880, 20'd327685, 20'd327685, 20'd327685, 20'd655320
    };
    localparam logic [0:6][23:0] GRAD_RGB = {
        24'h14233C, 24'h264B93, 24'h50C7E0, 24'h67BDAF, 24'hDC7969, 24'hF48420, 24'hEC0F6C
    };
    // Raw scores that fall on or next to each stop of the gradient.
    localparam logic [0:6][15:0] STOP_SCORES = {
        16'd0, 16'd2304, 16'd4608, 16'd7680, 16'd10752, 16'd13824, 16'd15360
    };

    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [BUCKET_W-1:0] bucket;
        logic [SCORE_W-1:0]  score;
    } sample_t;

    typedef struct packed {
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [POSZ_W-1:0]  z;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } vertex_t;

    typedef struct packed {
        sample_t smp;
        logic    typed;
        vertex_t vx;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    scv_sample_if sample_bus ();
    scv_vertex_if vertex_bus ();
    scv_cfg_if    cfg_bus ();

    score_colormap_vertex_gen dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_bus),
        .vertex_out (vertex_bus),
        .cfg        (cfg_bus)
    );

    vertex_t          expect_buf [0:EXPECT_DEPTH-1];
    stim_row_t        stim_table [0:STIM_ROWS-1];
    logic [ZSP_W-1:0] spacing_now;
    logic [ZSP_W-1:0] spacing_plan [0:RANDOM_PHASES-1];
    int               expect_wr        = 0;
    int               expect_rd        = 0;
    int               mismatch_count   = 0;
    int               vertices_checked = 0;
    int               samples_sent     = 0;
    int               burst_left       = 0;
    logic [9:0]       stall_tick       = '0;

    always #CLK_HALF clk = ~clk;

    // One colour channel between two stops; the step magnitude is rounded, ties up.
    function automatic logic [COLOR_W-1:0] lerp_channel(input logic [COLOR_W-1:0] lo,
                                                        input logic [COLOR_W-1:0] hi,
                                                        input longint unsigned frac);
        longint unsigned diff;
        longint unsigned step;
        if (hi >= lo)
        begin
            diff = longint'(hi) - longint'(lo);
            step = (frac * diff + 32768) >> 16;
            return lo + step[COLOR_W-1:0];
        end
        diff = longint'(lo) - longint'(hi);
        step = (frac * diff + 32768) >> 16;
        return lo - step[COLOR_W-1:0];
    endfunction

    // Position and gradient colour of the vertex that one sample should produce.
    function automatic vertex_t predict_vertex(input sample_t s, input logic [ZSP_W-1:0] zsp);
        longint unsigned day_v;
        longint unsigned bkt_v;
        longint unsigned scr;
        longint unsigned t;
        longint unsigned frac;
        int              seg;
        int              i;
        vertex_t         v;
        day_v = s.day;
        bkt_v = s.bucket;
        scr   = s.score;
        if (day_v >= DAY_COUNT_MAX_DEF)
            day_v = DAY_COUNT_MAX_DEF - 1;
        if (bkt_v >= BUCKET_COUNT_MAX_DEF)
            bkt_v = BUCKET_COUNT_MAX_DEF - 1;
        v.x = POS_W'((bkt_v * 256 + 12) / 25);
        v.y = POS_W'((scr + 2) / 5);
        v.z = POSZ_W'(day_v * zsp);

        // Gradient position, saturated at one once the score reaches sixty.
        t = (scr * 64) / 15;
        if (t > 65536)
            t = 65536;

        // The lowest segment whose upper stop is at or above t.
        seg = GRAD_SEGS - 1;
        for (i = GRAD_SEGS - 1; i >= 0; i--)
            if (t <= GRAD_POS[i + 1])
                seg = i;

        frac = (t >= GRAD_POS[seg]) ? t - GRAD_POS[seg] : 0;
        frac = (frac * GRAD_RECIP[seg] + 32768) >> 16;
        if (frac > 65536)
            frac = 65536;

        v.r = lerp_channel(GRAD_RGB[seg][23:16], GRAD_RGB[seg + 1][23:16], frac);
        v.g = lerp_channel(GRAD_RGB[seg][15:8],  GRAD_RGB[seg + 1][15:8],  frac);
        v.b = lerp_channel(GRAD_RGB[seg][7:0],   GRAD_RGB[seg + 1][7:0],   frac);
        return v;
    endfunction

    // Mostly scores inside the gradient range, with a share close to the stops and above sixty.
    function automatic sample_t random_sample();
        sample_t s;
        int      sc;
        int      pick;
        s.day    = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00)
                                               : DAY_W'($urandom_range(0, 255));
        s.bucket = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 10'h3FF : 10'h000)
                                               : BUCKET_W'($urandom_range(0, 1023));
        pick = int'($urandom_range(0, 9));
        if (pick <= 4)
            s.score = SCORE_W'($urandom_range(0, 15360));
        else if (pick <= 6)
        begin
            sc = int'(STOP_SCORES[$urandom_range(0, 6)]) + int'($urandom_range(0, 6)) - 3;
            if (sc < 0)
                sc = 0;
            s.score = SCORE_W'(sc);
        end
        else if (pick == 7)
            s.score = SCORE_W'($urandom_range(0, 65535));
        else if (pick == 8)
            s.score = SCORE_W'($urandom_range(15360, 65535));
        else
            s.score = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return s;
    endfunction

    // Table row checked against the predictor.
    function automatic stim_row_t pred_row(input int day, input int bucket, input int score);
        stim_row_t row;
        row.smp.day    = DAY_W'(day);
        row.smp.bucket = BUCKET_W'(bucket);
        row.smp.score  = SCORE_W'(score);
        row.typed      = 1'b0;
        row.vx         = '0;
        return row;
    endfunction

    // Table row with the vertex written out by hand.
    function automatic stim_row_t known_row(input int day, input int bucket, input int score,
                                            input int x, input int y, input int z,
                                            input logic [23:0] rgb);
        stim_row_t row;
        row = pred_row(day, bucket, score);
        row.typed = 1'b1;
        row.vx.x  = POS_W'(x);
        row.vx.y  = POS_W'(y);
        row.vx.z  = POSZ_W'(z);
        row.vx.r  = rgb[23:16];
        row.vx.g  = rgb[15:8];
        row.vx.b  = rgb[7:0];
        return row;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("vertex %0d: %s expected 0x%0h, got 0x%0h",
                         vertices_checked, name, want, got);
        end
    endfunction

    // Present one sample request, hold it until taken, then keep to the burst pattern.
    task automatic send_sample(input sample_t s, input logic typed, input vertex_t typed_vx);
        int gap;
        sample_bus.valid        <= 1'b1;
        sample_bus.day_index    <= s.day;
        sample_bus.bucket_index <= s.bucket;
        sample_bus.score        <= s.score;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        expect_buf[expect_wr % EXPECT_DEPTH] = typed ? typed_vx : predict_vertex(s, spacing_now);
        expect_wr++;
        samples_sent++;

        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = int'($urandom_range(1, 24));
            gap = ($urandom_range(0, 9) < 3) ? 0 : int'($urandom_range(1, 6));
            if (gap > 0)
            begin
                sample_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_spacing(input logic [ZSP_W-1:0] value);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.row_pitch <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
        spacing_now = value;
    endtask

    task automatic wait_drained();
        while (expect_wr != expect_rd)
            @(posedge clk);
    endtask

    // Output stalls: cycles through always-ready, light, heavy and a fixed duty pattern.
    always @(posedge clk)
    begin : vertex_stall
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[9:8])
            2'd0:    vertex_bus.ready <= 1'b1;
            2'd1:    vertex_bus.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    vertex_bus.ready <= ($urandom_range(0, 3) == 0);
            default: vertex_bus.ready <= (stall_tick[2:0] > 3'd2);
        endcase
    end

    // Compare each accepted vertex with the oldest expectation.
    always @(posedge clk)
    begin : vertex_check
        vertex_t want;
        if (rst_n && vertex_bus.valid && vertex_bus.ready)
        begin
            if (expect_wr == expect_rd)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("vertex %0d arrived with nothing expected: x=0x%0h y=0x%0h z=0x%0h",
                             vertices_checked, vertex_bus.pos_x, vertex_bus.pos_y,
                             vertex_bus.pos_z);
            end
            else
            begin
                want = expect_buf[expect_rd % EXPECT_DEPTH];
                expect_rd++;
                check_field("pos_x", want.x, vertex_bus.pos_x);
                check_field("pos_y", want.y, vertex_bus.pos_y);
                check_field("pos_z", want.z, vertex_bus.pos_z);
                check_field("red",   want.r, vertex_bus.red);
                check_field("green", want.g, vertex_bus.green);
                check_field("blue",  want.b, vertex_bus.blue);
            end
            vertices_checked++;
        end
    end

    // Overall time limit.
    initial
    begin
        #(TIMEOUT_NS);
        $display("score_colormap_vertex_gen_test: done, errors");
        $finish;
    end

    initial
    begin
        sample_bus.valid        <= 1'b0;
        sample_bus.day_index    <= '0;
        sample_bus.bucket_index <= '0;
        sample_bus.score        <= '0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.row_pitch       <= '0;
        spacing_now = SPACING_RESET;

        // Directed table, run with the spacing left at its reset value of 1.0.
        // Zero score gives the first stop; sixty and above give the last one.
        stim_table[0]  = known_row(0, 0, 16'h0000, 0, 0, 0, 24'h14233C);
        stim_table[1]  = known_row(255, 1023, 16'hFFFF, 10476, 13107, 65280, 24'hEC0F6C);
        stim_table[2]  = known_row(1, 25, 16'd15360, 256, 3072, 256, 24'hEC0F6C);
        // Smallest score step, each inner stop, some neighbours, and alternating bit patterns.
        stim_table[3]  = pred_row(2, 1, 1);
        stim_table[4]  = pred_row(3, 12, 2304);
        stim_table[5]  = pred_row(4, 13, 2305);
        stim_table[6]  = pred_row(5, 24, 4609);
        stim_table[7]  = pred_row(6, 10'h2AA, 4608);
        stim_table[8]  = pred_row(8'h55, 10'h155, 7680);
        stim_table[9]  = pred_row(8'hAA, 511, 10752);
        stim_table[10] = pred_row(8'h80, 512, 13824);
        stim_table[11] = pred_row(8'h7F, 1000, 15359);
        stim_table[12] = pred_row(9, 7, 16'h5555);
        stim_table[13] = pred_row(10, 8, 16'hAAAA);
        stim_table[14] = pred_row(254, 1022, 16'h8000);
        stim_table[15] = pred_row(11, 3, 16'h00FF);
        stim_table[16] = pred_row(12, 9, 16'h0F00);
        stim_table[17] = pred_row(13, 37, 16'hFFFE);

        // Spacing settings for the random phases: both extremes, one lsb, top bit, random.
        spacing_plan[0] = 16'h0000;
        spacing_plan[1] = 16'hFFFF;
        spacing_plan[2] = 16'h0001;
        spacing_plan[3] = 16'h8000;
        spacing_plan[4] = ZSP_W'($urandom_range(0, 65535));
        spacing_plan[5] = ZSP_W'($urandom_range(0, 65535));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[k])
            send_sample(stim_table[k].smp, stim_table[k].typed, stim_table[k].vx);
        sample_bus.valid <= 1'b0;

        // Random phases; the spacing is only changed once the pipeline has drained.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            write_spacing(spacing_plan[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_sample(random_sample(), 1'b0, '0);
            sample_bus.valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run sent %0d samples and checked %0d vertices over %0d row pitch settings.",
                 samples_sent, vertices_checked, RANDOM_PHASES + 1);
        $display("Scores spanned every gradient segment and stop; %0d field mismatches seen.",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("score_colormap_vertex_gen_test: done, clean");
        else
            $display("score_colormap_vertex_gen_test: done, errors");
        $finish;
    end

endmodule
